// ===== hw/rtl/lrwt_pkg.sv =====
// shared types, constants and helpers for the lru reply watermark table
// no dependencies; imported by the top level
package lrwt_pkg;

	localparam int CAPACITY     = 16;
	localparam int MAX_ID_BYTES = 8;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LEN_W = $clog2(MAX_ID_BYTES + 1);
	localparam int KEY_W = 64;
	localparam int ROW_W = 64;
	localparam int USE_W = 64;
	localparam int RAW_LEN_W = 8;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
		logic [ROW_W-1:0] wm;
		logic [USE_W-1:0] last_use;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// saturate the raw length to the key size
	function automatic logic [LEN_W-1:0] eff_len(input logic [RAW_LEN_W-1:0] raw);
		logic [LEN_W-1:0] len;
		if (raw > RAW_LEN_W'(MAX_ID_BYTES)) begin
			len = LEN_W'(MAX_ID_BYTES);
		end else begin
			len = raw[LEN_W-1:0];
		end
		return len;
	endfunction

	// keep only the bytes below the effective length
	function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
		logic [KEY_W-1:0] mask;
		for (int b = 0; b < KEY_W / 8; b++) begin
			mask[b*8 +: 8] = (b < int'(len)) ? 8'hff : 8'h00;
		end
		return mask;
	endfunction

endpackage

// ===== hw/rtl/lrwt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module lrwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/lru_reply_watermark_table.sv =====
// Keyed reply table of CAPACITY entries with LRU replacement and a per-key
// row id watermark. The entry memory has one read port, so one entry is
// examined per cycle for match and LRU age; then a drain state closes the
// last comparison and a finish state writes back and loads the result once
// the output register is free; only a record with a positive row id is written.
// in_stall is high while an item is at work; the result sits in an output
// register, so a new item is taken while the previous result still waits.
// Valid bits live in flip-flops cleared by reset, so no clearing pass is run.
// depends on lrwt_pkg and lrwt_ram
module lru_reply_watermark_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [lrwt_pkg::KEY_W-1:0]     chat_key,
	input  logic [lrwt_pkg::RAW_LEN_W-1:0] chat_len,
	input  logic signed [lrwt_pkg::ROW_W-1:0] row_id,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           already_replied,
	output logic                           entry_found,
	output logic                           accepted
);

	import lrwt_pkg::*;

	state_t state_q, state_d;

	logic [IDX_W-1:0] cnt_q;
	logic [CAPACITY-1:0] valid_q;
	logic [USE_W-1:0] use_counter_q;

	// item under work
	logic op_q;
	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] len_q;
	logic [ROW_W-1:0] row_q;

	// scan results
	logic found_q;
	logic [IDX_W-1:0] slot_q;
	logic [ROW_W-1:0] wm_q;
	logic [IDX_W-1:0] lru_idx_q;
	logic [USE_W-1:0] lru_use_q;

	logic cmp_s1;
	logic [IDX_W-1:0] idx_s1;

	logic out_valid_q, replied_q, found_out_q, accepted_q;

	logic in_take, ram_re, ram_we, load_out, out_free;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t rd_entry, wr_entry;
	logic [IDX_W-1:0] wr_idx, free_idx;
	logic free_any, hit, row_pos;
	logic [ROW_W-1:0] new_wm;
	logic [USE_W-1:0] next_use;

	lrwt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx),
		.wdata(wr_entry),
		.re   (ram_re),
		.raddr(cnt_q),
		.rdata(ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);
	assign hit = valid_q[idx_s1] && (rd_entry.len == len_q) && (rd_entry.key == key_q);
	assign row_pos = !row_q[ROW_W-1] && (|row_q);
	assign out_free = !out_valid_q || !out_stall;
	assign next_use = use_counter_q + USE_W'(1);

	// lowest free entry
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
				free_any = 1'b1;
			end
		end
	end

	always_comb begin
		if (found_q) begin
			wr_idx = slot_q;
		end else if (free_any) begin
			wr_idx = free_idx;
		end else begin
			wr_idx = lru_idx_q;
		end
		if (found_q && ($signed(wm_q) >= $signed(row_q))) begin
			new_wm = wm_q;
		end else begin
			new_wm = row_q;
		end
		wr_entry.key = key_q;
		wr_entry.len = len_q;
		wr_entry.wm = new_wm;
		wr_entry.last_use = next_use;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q == IDX_W'(CAPACITY - 1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall = 1'b1;
		ram_re = 1'b0;
		ram_we = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SCAN: begin
				ram_re = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_FINISH: begin
				load_out = out_free;
				ram_we = out_free && row_pos && (op_q == OP_RECORD);
			end
			default: begin
			end
		endcase
	end

	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			valid_q <= '0;
			use_counter_q <= '0;
			cmp_s1 <= 1'b0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cmp_s1 <= ram_re;
			if (in_take) begin
				cnt_q <= '0;
				found_q <= 1'b0;
			end else if (ram_re) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			if (cmp_s1 && hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (ram_we) begin
				valid_q[wr_idx] <= 1'b1;
				use_counter_q <= next_use;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q <= operation;
			len_q <= eff_len(chat_len);
			key_q <= chat_key & key_mask(eff_len(chat_len));
			row_q <= row_id;
		end
		idx_s1 <= cnt_q;
		if (cmp_s1) begin
			if (hit && !found_q) begin
				slot_q <= idx_s1;
				wm_q <= rd_entry.wm;
			end
			// strict compare keeps the lowest index on a tie
			if ((idx_s1 == '0) || (rd_entry.last_use < lru_use_q)) begin
				lru_idx_q <= idx_s1;
				lru_use_q <= rd_entry.last_use;
			end
		end
		if (load_out) begin
			accepted_q <= row_pos;
			found_out_q <= row_pos && found_q;
			replied_q <= row_pos && (op_q == OP_QUERY) && found_q
				&& ($signed(wm_q) >= $signed(row_q));
		end
	end

	assign out_valid = out_valid_q;
	assign already_replied = replied_q;
	assign entry_found = found_out_q;
	assign accepted = accepted_q;

	// a write-back leaves its entry valid
	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(wr_idx)])
		else $error("entry not valid after write-back");

	// a matched entry must be a valid one when the result is formed
	a_found_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && found_q) |-> valid_q[slot_q])
		else $error("match points at an invalid entry");

	// each record write advances the sequence counter by one; nothing else moves it
	a_counter_moves_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (use_counter_q == $past(use_counter_q) + USE_W'(1)))
		else $error("use counter did not advance on record");

	// nothing is accepted while an item is at work
	a_no_take_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");

endmodule
